[src/long_press_erase_gesture_core_defines.svh]
// ----------------------------------------------------------------------------
// long press erase gesture assertion macros
// shared property wrappers for the checker, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_ERASE_GESTURE_CORE_DEFINES_SVH
`define LONG_PRESS_ERASE_GESTURE_CORE_DEFINES_SVH

// property checked only out of reset
`define LPEG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define LPEG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/lpeg_pkg.sv]
// ----------------------------------------------------------------------------
// lpeg_pkg
// types, constants and helpers shared by the long press erase gesture core
// ----------------------------------------------------------------------------
package lpeg_pkg;

    localparam logic [15:0] SAT16_MAX       = 16'hFFFF;
    localparam logic [8:0]  PERIOD_START_MS = 9'd500;
    localparam logic [8:0]  PERIOD_SPAN_MS  = 9'd400;
    localparam logic [15:0] ARM_RESET_MS    = 16'd6000;
    localparam logic [9:0]  GAP_RESET_MS    = 10'd60;

    // held * span is 25 bits, quotient stays below 400 so 9 bits suffice
    localparam int PROD_W    = 25;
    localparam int QUO_W     = 9;
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    // configuration register indexes
    localparam logic CFG_ARM_TIME    = 1'b0;
    localparam logic CFG_REPAINT_GAP = 1'b1;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_DONE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        RING_NONE = 2'd0,
        RING_RED  = 2'd1,
        RING_OFF  = 2'd2
    } ring_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK,
        ST_DIV,
        ST_BLINK,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic resolve;
        logic accum;
        logic arm;
        logic mul;
        logic div_step;
        logic blink;
        logic out_load;
    } lpeg_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic at_limit;
        logic div_last;
        logic out_free;
    } lpeg_stat_t;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [9:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {7'd0, b};
        return s[16] ? SAT16_MAX : s[15:0];
    endfunction

endpackage

[src/lpeg_ctrl.sv]
// ----------------------------------------------------------------------------
// lpeg_ctrl
// sequencing state machine for the long press erase gesture core
// ----------------------------------------------------------------------------
module lpeg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpeg_pkg::lpeg_stat_t stat,
    output lpeg_pkg::lpeg_cmd_t  cmd
);

    lpeg_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpeg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            lpeg_pkg::ST_IDLE: begin
                // no request taken while reset is held
                s_ready     = aresetn;
                cmd.capture = s_valid && aresetn;
                if (s_valid && aresetn) begin
                    state_next = lpeg_pkg::ST_DECIDE;
                end
            end
            lpeg_pkg::ST_DECIDE: begin
                if (stat.tick_run) begin
                    cmd.accum  = 1'b1;
                    state_next = lpeg_pkg::ST_CHECK;
                end else begin
                    cmd.resolve = 1'b1;
                    state_next  = lpeg_pkg::ST_OUT;
                end
            end
            lpeg_pkg::ST_CHECK: begin
                if (stat.at_limit) begin
                    cmd.arm    = 1'b1;
                    state_next = lpeg_pkg::ST_OUT;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = lpeg_pkg::ST_DIV;
                end
            end
            lpeg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = lpeg_pkg::ST_BLINK;
                end
            end
            lpeg_pkg::ST_BLINK: begin
                cmd.blink  = 1'b1;
                state_next = lpeg_pkg::ST_OUT;
            end
            lpeg_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = lpeg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpeg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/lpeg_datapath.sv]
// ----------------------------------------------------------------------------
// lpeg_datapath
// gesture state, serial divider and result registers
// ----------------------------------------------------------------------------
module lpeg_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_action,
    input  logic                 s_button_down,
    input  logic [9:0]           s_elapsed_ms,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_led_armed,
    output logic [1:0]           m_ring_command,
    output logic                 m_finished,
    output logic                 m_erase,
    input  lpeg_pkg::lpeg_cmd_t  cmd,
    output lpeg_pkg::lpeg_stat_t stat
);

    // configuration
    logic [15:0] arm_time_reg;
    logic [9:0]  gap_reg;

    // gesture state
    lpeg_pkg::mode_t mode_reg, mode_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] phase_reg, phase_next;
    logic [15:0] since_reg, since_next;
    logic        blink_reg, blink_next;
    logic        armed_reg, armed_next;
    logic        ring_on_reg, ring_on_next;

    // captured request
    logic       in_action_reg;
    logic       in_down_reg;
    logic [9:0] in_elapsed_reg;

    // pending result
    logic            res_led_reg, res_led_next;
    lpeg_pkg::ring_t res_ring_reg, res_ring_next;
    logic            res_fin_reg, res_fin_next;
    logic            res_erase_reg, res_erase_next;

    // divider
    logic [15:0]                    rem_reg, rem_next;
    logic [lpeg_pkg::QUO_W-1:0]     lo_reg, lo_next;
    logic [lpeg_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [lpeg_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    // output stage
    logic            m_valid_reg;
    logic            m_led_reg;
    lpeg_pkg::ring_t m_ring_reg;
    logic            m_fin_reg;
    logic            m_erase_reg;

    logic [lpeg_pkg::PROD_W-1:0] product;
    logic [16:0] trial;
    logic [16:0] trial_diff;
    logic        trial_ge;
    logic [8:0]  period;
    logic [7:0]  half;
    logic [15:0] phase_sum;
    logic        phase_hit;
    logic        blink_new;
    logic        repaint;

    assign product    = lpeg_pkg::PROD_W'(held_reg) * lpeg_pkg::PROD_W'(lpeg_pkg::PERIOD_SPAN_MS);
    assign trial      = {rem_reg, lo_reg[lpeg_pkg::QUO_W-1]};
    assign trial_ge   = trial >= {1'b0, arm_time_reg};
    assign trial_diff = trial - {1'b0, arm_time_reg};

    assign period    = lpeg_pkg::PERIOD_START_MS - quo_reg;
    assign half      = period[8:1];
    assign phase_sum = lpeg_pkg::sat_add16(phase_reg, in_elapsed_reg);
    assign phase_hit = phase_sum >= {8'd0, half};
    assign blink_new = phase_hit ? !blink_reg : blink_reg;
    assign repaint   = (blink_new != ring_on_reg) && (since_reg >= {6'd0, gap_reg});

    assign stat.tick_run = in_action_reg && (mode_reg == lpeg_pkg::MODE_RUN) && in_down_reg;
    assign stat.at_limit = held_reg >= arm_time_reg;
    assign stat.div_last = cnt_reg == lpeg_pkg::DIV_LAST;
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        mode_next      = mode_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        since_next     = since_reg;
        blink_next     = blink_reg;
        armed_next     = armed_reg;
        ring_on_next   = ring_on_reg;
        res_led_next   = res_led_reg;
        res_ring_next  = res_ring_reg;
        res_fin_next   = res_fin_reg;
        res_erase_next = res_erase_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;

        if (cmd.resolve) begin
            res_led_next   = 1'b0;
            res_ring_next  = lpeg_pkg::RING_NONE;
            res_fin_next   = 1'b0;
            res_erase_next = 1'b0;
            if (!in_action_reg) begin
                if (mode_reg == lpeg_pkg::MODE_WAIT) begin
                    held_next    = '0;
                    phase_next   = '0;
                    blink_next   = 1'b0;
                    armed_next   = 1'b0;
                    ring_on_next = 1'b0;
                    since_next   = lpeg_pkg::SAT16_MAX;
                    mode_next    = in_down_reg ? lpeg_pkg::MODE_RUN : lpeg_pkg::MODE_DONE;
                    res_fin_next = !in_down_reg;
                end else if (mode_reg == lpeg_pkg::MODE_DONE) begin
                    res_fin_next = 1'b1;
                end
            end else if (mode_reg == lpeg_pkg::MODE_DONE) begin
                res_fin_next = 1'b1;
            end else if (mode_reg == lpeg_pkg::MODE_RUN) begin
                // release
                mode_next      = lpeg_pkg::MODE_DONE;
                res_ring_next  = lpeg_pkg::RING_OFF;
                res_fin_next   = 1'b1;
                res_erase_next = armed_reg;
                ring_on_next   = 1'b0;
            end
        end

        if (cmd.accum) begin
            held_next  = lpeg_pkg::sat_add16(held_reg, in_elapsed_reg);
            since_next = lpeg_pkg::sat_add16(since_reg, in_elapsed_reg);
        end

        if (cmd.arm) begin
            res_led_next   = 1'b1;
            res_fin_next   = 1'b0;
            res_erase_next = 1'b0;
            res_ring_next  = armed_reg ? lpeg_pkg::RING_NONE : lpeg_pkg::RING_RED;
            if (!armed_reg) begin
                ring_on_next = 1'b1;
            end
            armed_next = 1'b1;
        end

        if (cmd.mul) begin
            rem_next = product[lpeg_pkg::PROD_W-1:lpeg_pkg::QUO_W];
            lo_next  = product[lpeg_pkg::QUO_W-1:0];
            quo_next = '0;
            cnt_next = '0;
        end

        if (cmd.div_step) begin
            rem_next = trial_ge ? trial_diff[15:0] : trial[15:0];
            lo_next  = {lo_reg[lpeg_pkg::QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[lpeg_pkg::QUO_W-2:0], trial_ge};
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.blink) begin
            phase_next     = phase_hit ? 16'd0 : phase_sum;
            blink_next     = blink_new;
            res_led_next   = blink_new;
            res_fin_next   = 1'b0;
            res_erase_next = 1'b0;
            res_ring_next  = lpeg_pkg::RING_NONE;
            if (repaint) begin
                ring_on_next  = blink_new;
                since_next    = '0;
                res_ring_next = blink_new ? lpeg_pkg::RING_RED : lpeg_pkg::RING_OFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_time_reg <= lpeg_pkg::ARM_RESET_MS;
            gap_reg      <= lpeg_pkg::GAP_RESET_MS;
            mode_reg     <= lpeg_pkg::MODE_WAIT;
            held_reg     <= '0;
            phase_reg    <= '0;
            since_reg    <= lpeg_pkg::SAT16_MAX;
            blink_reg    <= 1'b0;
            armed_reg    <= 1'b0;
            ring_on_reg  <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == lpeg_pkg::CFG_ARM_TIME) begin
                    arm_time_reg <= cfg_wr_data;
                end else begin
                    gap_reg <= cfg_wr_data[9:0];
                end
            end
            mode_reg    <= mode_next;
            held_reg    <= held_next;
            phase_reg   <= phase_next;
            since_reg   <= since_next;
            blink_reg   <= blink_next;
            armed_reg   <= armed_next;
            ring_on_reg <= ring_on_next;
            cnt_reg     <= cnt_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_action_reg  <= s_action;
            in_down_reg    <= s_button_down;
            in_elapsed_reg <= s_elapsed_ms;
        end
        res_led_reg   <= res_led_next;
        res_ring_reg  <= res_ring_next;
        res_fin_reg   <= res_fin_next;
        res_erase_reg <= res_erase_next;
        rem_reg       <= rem_next;
        lo_reg        <= lo_next;
        quo_reg       <= quo_next;
        if (cmd.out_load) begin
            m_led_reg   <= res_led_reg;
            m_ring_reg  <= res_ring_reg;
            m_fin_reg   <= res_fin_reg;
            m_erase_reg <= res_erase_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_led_armed    = m_led_reg;
    assign m_ring_command = m_ring_reg;
    assign m_finished     = m_fin_reg;
    assign m_erase        = m_erase_reg;

endmodule

[src/long_press_erase_gesture_core.sv]
// ----------------------------------------------------------------------------
// long_press_erase_gesture_core
// long press erase gesture: boot check, held time, blink rate, arming, erase
// ----------------------------------------------------------------------------
// sequence: boot checks, releases and ignored requests go through decide and out,
//   a hold at the arm limit adds the limit check, and a blink tick adds the limit
//   check, the bit-serial restoring divider that scales held time into the blink
//   period, and the blink update; one request is taken at a time
// reset: synchronous active-low aresetn; registers return to 6000 ms / 60 ms,
//   the gesture waits for a boot check, and no result is pending
module long_press_erase_gesture_core (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wr_data,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic        s_button_down,
    input  logic [9:0]  s_elapsed_ms,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_led_armed,
    output logic [1:0]  m_ring_command,
    output logic        m_finished,
    output logic        m_erase
);

    // commands from the sequencer and status back from the datapath
    lpeg_pkg::lpeg_cmd_t  cmd;
    lpeg_pkg::lpeg_stat_t stat;

    // sequencer: takes a request only when idle, then walks it through decide and,
    // for a tick, limit check, divide and blink update before loading the result
    lpeg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: gesture state, config registers, serial divider and the
    // output register that lets a result wait while the next request is taken
    lpeg_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_action       (s_action),
        .s_button_down  (s_button_down),
        .s_elapsed_ms   (s_elapsed_ms),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_led_armed    (m_led_armed),
        .m_ring_command (m_ring_command),
        .m_finished     (m_finished),
        .m_erase        (m_erase),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

[src/lpeg_checker.sv]
// ----------------------------------------------------------------------------
// lpeg_checker
// port-level checks for the long press erase gesture core
// ----------------------------------------------------------------------------
`include "long_press_erase_gesture_core_defines.svh"

module lpeg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_led_armed,
    input logic [1:0]  m_ring_command,
    input logic        m_finished,
    input logic        m_erase
);

    // no result pending right after reset
    `LPEG_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // erase only comes with the release result
    `LPEG_ASSERT(a_erase_release, m_valid && m_erase |-> m_finished && (m_ring_command == lpeg_pkg::RING_OFF), "erase without release")

    // a finished gesture never shows the armed light
    `LPEG_ASSERT(a_fin_dark, m_valid && m_finished |-> !m_led_armed, "armed light on finished gesture")

    // one request at a time: no request taken right after another
    `LPEG_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "request taken back to back")

    // a stalled result holds
    `LPEG_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_ring_command) && $stable(m_erase) && $stable(m_finished) && $stable(m_led_armed), "stalled result changed")

endmodule

bind long_press_erase_gesture_core lpeg_checker u_lpeg_checker (.*);
